@@ src/assert_macros.svh @@
// Assertion macros shared by the split stream encoder RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MSS_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("mss assertion failed");

// Clocked assertion that also holds during reset.
`define MSS_ASSERT_ALWAYS(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) else $error("mss assertion failed");

`endif

@@ src/mss_pkg.sv @@
// Shared types, constants and functions for the split stream encoder.
// Used by the front end, the queue and the back end; no dependencies.
package mss_pkg;

	localparam logic [7:0] SYM_MAX_SHORT = 8'd253;
	localparam logic [7:0] SYM_ZERO8     = 8'd254;
	localparam logic [7:0] SYM_ONE8      = 8'd255;
	localparam logic [3:0] LEN_FULL      = 4'd8;
	localparam logic [3:0] LEN_SIDE_FULL = 4'd7;

	typedef struct packed {
		logic [7:0] pbits;
		logic [3:0] plen;
		logic       sbits;
		logic [3:0] slen;
	} code_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [6:0] pend;
		logic [2:0] cnt;
	} pack_t;

	function automatic code_t classify(input logic [7:0] sym);
		logic [7:0] v;
		logic [2:0] p;
		code_t      c;
		v = sym + 8'd2;
		p = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (v[i]) begin
				p = 3'(i);
			end
		end
		if (sym <= SYM_MAX_SHORT) begin
			c.plen  = {1'b0, p};
			c.pbits = v & ((8'd1 << p) - 8'd1);
			c.sbits = 1'b1;
			c.slen  = LEN_FULL - {1'b0, p};
		end else begin
			c.plen  = LEN_FULL;
			c.pbits = (sym == SYM_ONE8) ? 8'd1 : 8'd0;
			c.sbits = 1'b0;
			c.slen  = LEN_SIDE_FULL;
		end
		return c;
	endfunction

	function automatic pack_t pack_bits(input logic [6:0] pend, input logic [2:0] cnt,
		input logic [7:0] bits, input logic [3:0] len);
		logic [14:0] acc;
		logic [3:0]  total;
		logic [2:0]  rest;
		pack_t       r;
		acc   = ({8'd0, pend} << len) | {7'd0, bits};
		total = {1'b0, cnt} + len;
		rest  = total[2:0];
		if (total[3]) begin
			r.valid = 1'b1;
			r.data  = 8'(acc >> rest);
			r.pend  = 7'(acc & ((15'd1 << rest) - 15'd1));
			r.cnt   = rest;
		end else begin
			r.valid = 1'b0;
			r.data  = 8'd0;
			r.pend  = acc[6:0];
			r.cnt   = total[2:0];
		end
		return r;
	endfunction

endpackage

@@ src/mss_front.sv @@
// Front end of the split stream encoder: accepts symbols and classifies them
// into payload and side codes held in one pipeline register. Uses mss_pkg.
module mss_front import mss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] symbol,
	output logic       code_valid,
	input  logic       code_ready,
	output code_t      code
);

	logic  valid_s1;
	code_t code_s1;

	assign in_ready   = !valid_s1 || code_ready;
	assign code_valid = valid_s1;
	assign code       = code_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= classify(symbol);
		end
	end

endmodule

@@ src/mss_queue.sv @@
// Two-entry queue of classified codes between the front and back ends.
// Uses mss_pkg types and the assertion macros.
`include "assert_macros.svh"
module mss_queue import mss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  code_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output code_t pop_data
);

	code_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`MSS_ASSERT(a_cnt_bound, clk, arst_n, cnt_q != 2'd3)
	`MSS_ASSERT(a_ptr_track, clk, arst_n, (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
	`MSS_ASSERT_ALWAYS(a_rst_empty, clk, !arst_n |=> (cnt_q == 2'd0))

endmodule

@@ src/mss_back.sv @@
// Back end of the split stream encoder: packs payload and side codes into
// bytes and holds each result in an output register. Uses mss_pkg and macros.
`include "assert_macros.svh"
module mss_back import mss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       code_valid,
	output logic       code_ready,
	input  code_t      code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic       side_valid,
	output logic [7:0] side_byte
);

	logic [6:0] pay_pend_q;
	logic [2:0] pay_cnt_q;
	logic [6:0] side_pend_q;
	logic [2:0] side_cnt_q;
	logic       out_valid_q;
	logic       pay_valid_q;
	logic [7:0] pay_byte_q;
	logic       side_valid_q;
	logic [7:0] side_byte_q;
	pack_t      pay_next;
	pack_t      side_next;
	logic       pop;

	assign code_ready = !out_valid_q || out_ready;
	assign pop        = code_valid && code_ready;

	assign pay_next  = pack_bits(pay_pend_q, pay_cnt_q, code.pbits, code.plen);
	assign side_next = pack_bits(side_pend_q, side_cnt_q, {7'd0, code.sbits}, code.slen);

	assign out_valid     = out_valid_q;
	assign payload_valid = pay_valid_q;
	assign payload_byte  = pay_byte_q;
	assign side_valid    = side_valid_q;
	assign side_byte     = side_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_pend_q  <= 7'd0;
			pay_cnt_q   <= 3'd0;
			side_pend_q <= 7'd0;
			side_cnt_q  <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (code_ready) begin
				out_valid_q <= code_valid;
			end
			if (pop) begin
				pay_pend_q  <= pay_next.pend;
				pay_cnt_q   <= pay_next.cnt;
				side_pend_q <= side_next.pend;
				side_cnt_q  <= side_next.cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pay_valid_q  <= pay_next.valid;
			pay_byte_q   <= pay_next.data;
			side_valid_q <= side_next.valid;
			side_byte_q  <= side_next.data;
		end
	end

	`MSS_ASSERT(a_pop_loads, clk, arst_n, pop |=> out_valid_q)
	`MSS_ASSERT(a_hold_state, clk, arst_n, !pop |=> ($stable(pay_cnt_q) && $stable(side_cnt_q)))
	`MSS_ASSERT(a_idle_zero, clk, arst_n,
		(out_valid_q && !pay_valid_q) |-> (pay_byte_q == 8'd0))

endmodule

@@ src/mbr_split_stream_encoder.sv @@
// Split stream encoder: each accepted symbol byte yields one result carrying at most one
// finished payload byte and one finished side (length code) byte, both packed MSB first.
// The block takes one item per clock unless out_ready stalls it, a rate set by the bit packer
// of the back end; each result passes through the front pipeline register, the queue and the
// back end output register. Bits still pending at the end of a stream are never flushed.
module mbr_split_stream_encoder import mss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic       side_valid,
	output logic [7:0] side_byte
);

	logic  f_valid;
	logic  f_ready;
	code_t f_code;
	logic  q_valid;
	logic  q_ready;
	code_t q_code;

	mss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.symbol     (symbol),
		.code_valid (f_valid),
		.code_ready (f_ready),
		.code       (f_code)
	);

	mss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_code),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_code)
	);

	mss_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.code_valid    (q_valid),
		.code_ready    (q_ready),
		.code          (q_code),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.side_valid    (side_valid),
		.side_byte     (side_byte)
	);

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for mbr_split_stream_encoder: symbol items in, packed byte results out.
// Predicts both packed bit streams locally and checks every result, under varied idling.
// Depends on mss_pkg for the symbol constants and on the encoder RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mss_pkg::*;

	typedef enum logic [1:0] {PH_RX_SLOW, PH_TX_SLOW, PH_FULL} phase_t;

	typedef struct {
		logic       pv;
		logic [7:0] pbyte;
		logic       sv;
		logic [7:0] sbyte;
	} enc_result_t;

	typedef struct {
		logic       done;
		logic [7:0] outb;
		logic [6:0] held;
		logic [2:0] nheld;
	} stream_step_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] symbol    = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic       side_valid;
	logic [7:0] side_byte;

	phase_t      phase = PH_RX_SLOW;
	logic [7:0]  symbol_backlog[$];
	enc_result_t expected_results[$];
	enc_result_t predicted;
	enc_result_t want;
	int unsigned mismatch_count = 0;
	int unsigned hold_left;
	logic        hold_done;

	logic [6:0] payload_held = 7'd0;
	logic [2:0] payload_nheld = 3'd0;
	logic [6:0] side_held = 7'd0;
	logic [2:0] side_nheld = 3'd0;

	mbr_split_stream_encoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.symbol       (symbol),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_valid(payload_valid),
		.payload_byte (payload_byte),
		.side_valid   (side_valid),
		.side_byte    (side_byte)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic stream_step_t append_code(input logic [6:0] held, input logic [2:0] nheld,
		input logic [7:0] code, input int unsigned nbits);
		logic [15:0]  acc;
		int unsigned  total;
		stream_step_t s;
		acc   = ({9'd0, held} << nbits) | ({8'd0, code} & ((16'd1 << nbits) - 16'd1));
		total = nheld + nbits;
		if (total >= 8) begin
			s.done  = 1'b1;
			s.outb  = 8'(acc >> (total - 8));
			s.held  = 7'(acc & ((16'd1 << (total - 8)) - 16'd1));
			s.nheld = 3'(total - 8);
		end else begin
			s.done  = 1'b0;
			s.outb  = 8'd0;
			s.held  = acc[6:0];
			s.nheld = 3'(total);
		end
		return s;
	endfunction

	task automatic encode_symbol(input logic [7:0] sym, output enc_result_t r);
		logic [8:0]   v;
		logic [7:0]   pcode;
		logic [7:0]   scode;
		int unsigned  plen;
		int unsigned  slen;
		stream_step_t ps;
		stream_step_t ss;
		if (sym > SYM_MAX_SHORT) begin
			plen  = 8;
			pcode = (sym == SYM_ONE8) ? 8'd1 : 8'd0;
			slen  = 7;
			scode = 8'd0;
		end else begin
			v    = {1'b0, sym} + 9'd2;
			plen = 0;
			for (int i = 1; i < 8; i++) begin
				if (v[i]) begin
					plen = i;
				end
			end
			pcode = 8'(v & ((9'd1 << plen) - 9'd1));
			slen  = 8 - plen;
			scode = 8'd1;
		end
		ps = append_code(payload_held, payload_nheld, pcode, plen);
		ss = append_code(side_held, side_nheld, scode, slen);
		payload_held  = ps.held;
		payload_nheld = ps.nheld;
		side_held     = ss.held;
		side_nheld    = ss.nheld;
		r.pv    = ps.done;
		r.pbyte = ps.outb;
		r.sv    = ss.done;
		r.sbyte = ss.outb;
	endtask

	function automatic logic [7:0] pick_symbol();
		int unsigned kind;
		int unsigned k;
		int unsigned lo;
		int unsigned hi;
		kind = $urandom_range(99);
		if (kind < 30) begin
			return 8'($urandom_range(255));
		end
		if (kind < 50) begin
			return $urandom_range(1) ? SYM_ONE8 : SYM_ZERO8;
		end
		// Pick a code length first so every length shows up often.
		k  = $urandom_range(7, 1);
		lo = (1 << k) - 2;
		hi = (1 << (k + 1)) - 3;
		if (hi > 253) begin
			hi = 253;
		end
		return 8'($urandom_range(hi, lo));
	endfunction

	function automatic int unsigned send_idle_pct(input phase_t ph);
		case (ph)
			PH_RX_SLOW: return 6;
			PH_TX_SLOW: return 87;
			default:    return 0;
		endcase
	endfunction

	function automatic int unsigned recv_stall_pct(input phase_t ph);
		case (ph)
			PH_RX_SLOW: return 87;
			PH_TX_SLOW: return 6;
			default:    return 0;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			symbol   <= 8'd0;
		end else begin
			if (in_valid && in_ready) begin
				encode_symbol(symbol, predicted);
				expected_results.push_back(predicted);
			end
			if (!in_valid || in_ready) begin
				if (symbol_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct(phase)) begin
					in_valid <= 1'b1;
					symbol   <= symbol_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The first cycle of the last phase starts a long output stall so the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (phase == PH_FULL && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct(phase));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result item arrived with no expected result pending");
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("payload_valid", {7'd0, want.pv}, {7'd0, payload_valid});
				check_field("payload_byte", want.pbyte, payload_byte);
				check_field("side_valid", {7'd0, want.sv}, {7'd0, side_valid});
				check_field("side_byte", want.sbyte, side_byte);
			end
		end
	end

	initial begin
		symbol_backlog = '{8'd0, 8'd1, 8'd2, 8'd5, 8'd6, 8'd13, 8'd14, 8'd29, 8'd30, 8'd61,
			8'd62, 8'd125, 8'd126, 8'd253, 8'd254, 8'd255, 8'd254, 8'd255, 8'd0, 8'd255,
			8'd128, 8'd127, 8'd170, 8'd85};
		repeat (360) symbol_backlog.push_back(pick_symbol());
		phase = PH_RX_SLOW;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (symbol_backlog.size() != 0) @(negedge clk);
		repeat (360) symbol_backlog.push_back(pick_symbol());
		phase = PH_TX_SLOW;

		while (symbol_backlog.size() != 0) @(negedge clk);
		repeat (360) symbol_backlog.push_back(pick_symbol());
		phase = PH_FULL;

		while (symbol_backlog.size() != 0 || in_valid) @(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
